@@ src/ir_distance_linearizer_macros.svh @@
// Assertion macros for the IR distance linearizer.
// Used by ir_distance_linearizer.sv; expects signals named clock and reset.
`ifndef IR_DISTANCE_LINEARIZER_MACROS_SVH
`define IR_DISTANCE_LINEARIZER_MACROS_SVH

// same-cycle implication
`define IDL_ASSERT_NOW(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("idl assertion failed");

// next-cycle implication
`define IDL_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("idl assertion failed");

`endif

@@ src/idl_pkg.sv @@
// Shared types, constants and helpers of the IR distance linearizer.
// No dependencies; used by idl_lane, idl_merge and ir_distance_linearizer.
package idl_pkg;

   localparam int SAMPLE_W = 10;
   localparam int GAIN_W   = 20;
   localparam int DIST_W   = 11;
   localparam int STEPS    = GAIN_W;
   localparam int CNT_W    = $clog2(STEPS);

   localparam int ADC_BITS       = 10;
   localparam int AVERAGE_ENABLE = 1;
   localparam logic signed [SAMPLE_W-1:0] FRONT_DIST_OFFSET = 10'sd0;
   localparam logic signed [SAMPLE_W-1:0] SIDE_DIST_OFFSET  = 10'sd0;

   localparam logic [SAMPLE_W-1:0] ADC_MASK =
      (ADC_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << ADC_BITS) - 1);

   localparam logic [13:0] BATT_MUL   = 14'd14837;
   localparam int          BATT_SHIFT = 16;

   localparam logic signed [DIST_W-1:0] FRONT_HELD_RESET = 11'sd80;
   localparam logic signed [DIST_W-1:0] SIDE_HELD_RESET  = 11'sd30;

   typedef enum logic [2:0] {
      REG_FRONT_GAIN   = 3'd0,
      REG_FRONT_OFFSET = 3'd1,
      REG_FRONT_MIN    = 3'd2,
      REG_FRONT_MAX    = 3'd3,
      REG_SIDE_GAIN    = 3'd4,
      REG_SIDE_OFFSET  = 3'd5,
      REG_SIDE_MIN     = 3'd6,
      REG_SIDE_MAX     = 3'd7
   } reg_index_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_BUSY = 1'b1
   } state_type;

   typedef struct packed {
      logic [GAIN_W-1:0]   gain;
      logic [SAMPLE_W-1:0] offs;
      logic [SAMPLE_W-1:0] lo;
      logic [SAMPLE_W-1:0] hi;
   } lane_cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } lane_stat_type;

   function automatic logic [SAMPLE_W-1:0] adc_value(input logic [SAMPLE_W-1:0] v);
      return v & ADC_MASK;
   endfunction

endpackage

@@ src/idl_lane.sv @@
// One conversion lane: restoring divider (one quotient bit per cycle),
// then distance offset and range clamp. Depends on idl_pkg.
module idl_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [idl_pkg::SAMPLE_W-1:0]        raw,
   input  idl_pkg::lane_cfg_type               cfg,
   input  logic signed [idl_pkg::SAMPLE_W-1:0] dist_off,
   output idl_pkg::lane_stat_type              stat,
   output logic signed [idl_pkg::DIST_W-1:0]   distance
);

   logic                                busy_ff, busy_in;
   logic                                wrap_ff, wrap_in;
   logic                                done_ff, done_in;
   logic [idl_pkg::CNT_W-1:0]           cnt_ff, cnt_in;
   logic [idl_pkg::DIST_W-1:0]          den_ff, den_in;
   logic                                den_zero_ff, den_zero_in;
   logic [idl_pkg::GAIN_W-1:0]          q_ff, q_in;
   logic [idl_pkg::DIST_W-1:0]          rem_ff, rem_in;
   logic signed [idl_pkg::DIST_W-1:0]   dist_ff, dist_in;

   logic [idl_pkg::DIST_W-1:0]          den;
   logic [idl_pkg::DIST_W+1:0]          trial;
   logic signed [idl_pkg::GAIN_W+1:0]   d;
   logic signed [idl_pkg::DIST_W-1:0]   above;
   logic signed [idl_pkg::DIST_W-1:0]   below;

   assign den   = {1'b0, raw} + {1'b0, cfg.offs};
   assign trial = {1'b0, rem_ff, q_ff[idl_pkg::GAIN_W-1]} - {2'b00, den_ff};

   assign d = $signed({2'b00, q_ff}) - (idl_pkg::GAIN_W+2)'(dist_off);
   assign above = (cfg.hi == {idl_pkg::SAMPLE_W{1'b1}}) ?
                  $signed({1'b0, cfg.hi}) :
                  $signed({1'b0, cfg.hi}) + 11'sd1;
   assign below = $signed({1'b0, cfg.lo}) - 11'sd1;

   always_comb begin
      busy_in     = busy_ff;
      wrap_in     = 1'b0;
      done_in     = done_ff;
      cnt_in      = cnt_ff;
      den_in      = den_ff;
      den_zero_in = den_zero_ff;
      q_in        = q_ff;
      rem_in      = rem_ff;
      dist_in     = dist_ff;
      if (start) begin
         busy_in     = 1'b1;
         done_in     = 1'b0;
         cnt_in      = '0;
         den_in      = den;
         den_zero_in = (den == '0);
         q_in        = cfg.gain;
         rem_in      = '0;
      end else if (busy_ff) begin
         if (!trial[idl_pkg::DIST_W+1]) begin
            rem_in = trial[idl_pkg::DIST_W-1:0];
            q_in   = {q_ff[idl_pkg::GAIN_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[idl_pkg::DIST_W-2:0], q_ff[idl_pkg::GAIN_W-1]};
            q_in   = {q_ff[idl_pkg::GAIN_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == idl_pkg::CNT_W'(idl_pkg::STEPS - 1)) begin
            busy_in = 1'b0;
            wrap_in = 1'b1;
         end
      end else if (wrap_ff) begin
         done_in = 1'b1;
         if (den_zero_ff) begin
            dist_in = above;
         end else if (d > $signed({12'd0, cfg.hi})) begin
            dist_in = above;
         end else if (d < $signed({12'd0, cfg.lo})) begin
            dist_in = below;
         end else begin
            dist_in = d[idl_pkg::DIST_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         wrap_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         wrap_ff <= wrap_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff      <= den_in;
      den_zero_ff <= den_zero_in;
      q_ff        <= q_in;
      rem_ff      <= rem_in;
      dist_ff     <= dist_in;
   end

   assign stat.busy = busy_ff | wrap_ff;
   assign stat.done = done_ff;
   assign distance  = dist_ff;

endmodule

@@ src/idl_merge.sv @@
// Merge stage: smooths the three lane distances into the held state,
// forms the side difference and battery tenths, holds the output word.
// Depends on idl_pkg.
module idl_merge (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  logic signed [idl_pkg::DIST_W-1:0]  front_fresh,
   input  logic signed [idl_pkg::DIST_W-1:0]  right_fresh,
   input  logic signed [idl_pkg::DIST_W-1:0]  left_fresh,
   input  logic [idl_pkg::SAMPLE_W-1:0]       battery_raw,
   output logic                               slot_free,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [idl_pkg::DIST_W-1:0]  rsp_front_distance,
   output logic signed [idl_pkg::DIST_W-1:0]  rsp_right_distance,
   output logic signed [idl_pkg::DIST_W-1:0]  rsp_left_distance,
   output logic signed [idl_pkg::DIST_W-1:0]  rsp_front_previous,
   output logic signed [idl_pkg::DIST_W-1:0]  rsp_right_previous,
   output logic signed [idl_pkg::DIST_W-1:0]  rsp_left_previous,
   output logic [idl_pkg::DIST_W-1:0]         rsp_side_difference,
   output logic [7:0]                         rsp_battery_tenths
);

   function automatic logic signed [idl_pkg::DIST_W-1:0] smooth(
      input logic signed [idl_pkg::DIST_W-1:0] held,
      input logic signed [idl_pkg::DIST_W-1:0] fresh);
      logic signed [idl_pkg::DIST_W:0] sum;
      logic signed [idl_pkg::DIST_W:0] adj;
      sum = (idl_pkg::DIST_W+1)'(held) + (idl_pkg::DIST_W+1)'(fresh);
      // truncate toward zero
      adj = sum + {{idl_pkg::DIST_W{1'b0}}, sum[idl_pkg::DIST_W]};
      if (idl_pkg::AVERAGE_ENABLE != 0) begin
         return adj[idl_pkg::DIST_W:1];
      end
      return fresh;
   endfunction

   logic                               valid_ff, valid_in;
   logic signed [idl_pkg::DIST_W-1:0]  front_held_ff, front_held_in;
   logic signed [idl_pkg::DIST_W-1:0]  right_held_ff, right_held_in;
   logic signed [idl_pkg::DIST_W-1:0]  left_held_ff, left_held_in;
   logic signed [idl_pkg::DIST_W-1:0]  front_prev_ff, right_prev_ff, left_prev_ff;
   logic [idl_pkg::DIST_W-1:0]         diff_ff, diff_in;
   logic [7:0]                         batt_ff, batt_in;

   logic signed [idl_pkg::DIST_W:0]    rl;
   logic [idl_pkg::SAMPLE_W+13:0]      batt_prod;

   assign slot_free = !valid_ff || !rsp_stall;

   assign front_held_in = smooth(front_held_ff, front_fresh);
   assign right_held_in = smooth(right_held_ff, right_fresh);
   assign left_held_in  = smooth(left_held_ff, left_fresh);

   assign rl      = (idl_pkg::DIST_W+1)'(right_held_in) - (idl_pkg::DIST_W+1)'(left_held_in);
   assign diff_in = rl[idl_pkg::DIST_W] ? idl_pkg::DIST_W'(-rl) : rl[idl_pkg::DIST_W-1:0];

   assign batt_prod = battery_raw * idl_pkg::BATT_MUL;
   assign batt_in   = batt_prod[idl_pkg::BATT_SHIFT +: 8];

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         front_held_ff <= idl_pkg::FRONT_HELD_RESET;
         right_held_ff <= idl_pkg::SIDE_HELD_RESET;
         left_held_ff  <= idl_pkg::SIDE_HELD_RESET;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            front_held_ff <= front_held_in;
            right_held_ff <= right_held_in;
            left_held_ff  <= left_held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         front_prev_ff <= front_held_ff;
         right_prev_ff <= right_held_ff;
         left_prev_ff  <= left_held_ff;
         diff_ff       <= diff_in;
         batt_ff       <= batt_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_front_distance  = front_held_ff;
   assign rsp_right_distance  = right_held_ff;
   assign rsp_left_distance   = left_held_ff;
   assign rsp_front_previous  = front_prev_ff;
   assign rsp_right_previous  = right_prev_ff;
   assign rsp_left_previous   = left_prev_ff;
   assign rsp_side_difference = diff_ff;
   assign rsp_battery_tenths  = batt_ff;

endmodule

@@ src/ir_distance_linearizer.sv @@
// Top level: config registers, control FSM, three conversion lanes, merge stage.
// Depends on idl_pkg, idl_lane, idl_merge and ir_distance_linearizer_macros.svh.
//
//   port group   direction   handshake           word
//   req_*        in          req_valid/req_stall three IR samples, battery sample
//   rsp_*        out         rsp_valid/rsp_stall distances, previous, diff, battery
//   csr_*        in          csr_wr_en           register index, 20-bit data
//
// Each word passes through the 20-step restoring divider in each lane, then the
// merge stage; no new word is taken until the previous one is loaded there.
// Synchronous reset loads the register reset values and held distances 80/30/30.
// A stalled result sits in the output register while the next word is taken.
`include "ir_distance_linearizer_macros.svh"

module ir_distance_linearizer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [idl_pkg::SAMPLE_W-1:0]       req_front_sample,
   input  logic [idl_pkg::SAMPLE_W-1:0]       req_right_sample,
   input  logic [idl_pkg::SAMPLE_W-1:0]       req_left_sample,
   input  logic [idl_pkg::SAMPLE_W-1:0]       req_battery_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [idl_pkg::DIST_W-1:0]  rsp_front_distance,
   output logic signed [idl_pkg::DIST_W-1:0]  rsp_right_distance,
   output logic signed [idl_pkg::DIST_W-1:0]  rsp_left_distance,
   output logic signed [idl_pkg::DIST_W-1:0]  rsp_front_previous,
   output logic signed [idl_pkg::DIST_W-1:0]  rsp_right_previous,
   output logic signed [idl_pkg::DIST_W-1:0]  rsp_left_previous,
   output logic [idl_pkg::DIST_W-1:0]         rsp_side_difference,
   output logic [7:0]                         rsp_battery_tenths,
   input  logic                               csr_wr_en,
   input  logic [2:0]                         csr_index,
   input  logic [idl_pkg::GAIN_W-1:0]         csr_data
);

   idl_pkg::state_type                 state_ff, state_in;
   idl_pkg::lane_cfg_type              front_cfg_ff, side_cfg_ff;
   logic [idl_pkg::SAMPLE_W-1:0]       batt_raw_ff;

   idl_pkg::lane_stat_type             front_stat, right_stat, left_stat;
   logic signed [idl_pkg::DIST_W-1:0]  front_dist, right_dist, left_dist;
   logic                               accept;
   logic                               all_done;
   logic                               slot_free;
   logic                               load;

   assign req_stall = (state_ff != idl_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign all_done  = front_stat.done && right_stat.done && left_stat.done;

   always_comb begin
      state_in = state_ff;
      load     = 1'b0;
      case (state_ff)
         idl_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = idl_pkg::ST_BUSY;
            end
         end
         idl_pkg::ST_BUSY: begin
            if (all_done && slot_free) begin
               load     = 1'b1;
               state_in = idl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = idl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= idl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_cfg_ff <= '{gain: '0, offs: '0, lo: '0, hi: 10'd1022};
         side_cfg_ff  <= '{gain: '0, offs: '0, lo: '0, hi: 10'd1022};
      end else if (csr_wr_en) begin
         case (idl_pkg::reg_index_type'(csr_index))
            idl_pkg::REG_FRONT_GAIN:   front_cfg_ff.gain <= csr_data;
            idl_pkg::REG_FRONT_OFFSET: front_cfg_ff.offs <= csr_data[idl_pkg::SAMPLE_W-1:0];
            idl_pkg::REG_FRONT_MIN:    front_cfg_ff.lo   <= csr_data[idl_pkg::SAMPLE_W-1:0];
            idl_pkg::REG_FRONT_MAX:    front_cfg_ff.hi   <= csr_data[idl_pkg::SAMPLE_W-1:0];
            idl_pkg::REG_SIDE_GAIN:    side_cfg_ff.gain  <= csr_data;
            idl_pkg::REG_SIDE_OFFSET:  side_cfg_ff.offs  <= csr_data[idl_pkg::SAMPLE_W-1:0];
            idl_pkg::REG_SIDE_MIN:     side_cfg_ff.lo    <= csr_data[idl_pkg::SAMPLE_W-1:0];
            idl_pkg::REG_SIDE_MAX:     side_cfg_ff.hi    <= csr_data[idl_pkg::SAMPLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         batt_raw_ff <= idl_pkg::adc_value(req_battery_sample);
      end
   end

   idl_lane u_front_lane (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .raw      (idl_pkg::adc_value(req_front_sample)),
      .cfg      (front_cfg_ff),
      .dist_off (idl_pkg::FRONT_DIST_OFFSET),
      .stat     (front_stat),
      .distance (front_dist)
   );

   idl_lane u_right_lane (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .raw      (idl_pkg::adc_value(req_right_sample)),
      .cfg      (side_cfg_ff),
      .dist_off (idl_pkg::SIDE_DIST_OFFSET),
      .stat     (right_stat),
      .distance (right_dist)
   );

   idl_lane u_left_lane (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .raw      (idl_pkg::adc_value(req_left_sample)),
      .cfg      (side_cfg_ff),
      .dist_off (idl_pkg::SIDE_DIST_OFFSET),
      .stat     (left_stat),
      .distance (left_dist)
   );

   idl_merge u_merge (
      .clock               (clock),
      .reset               (reset),
      .load                (load),
      .front_fresh         (front_dist),
      .right_fresh         (right_dist),
      .left_fresh          (left_dist),
      .battery_raw         (batt_raw_ff),
      .slot_free           (slot_free),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_front_distance  (rsp_front_distance),
      .rsp_right_distance  (rsp_right_distance),
      .rsp_left_distance   (rsp_left_distance),
      .rsp_front_previous  (rsp_front_previous),
      .rsp_right_previous  (rsp_right_previous),
      .rsp_left_previous   (rsp_left_previous),
      .rsp_side_difference (rsp_side_difference),
      .rsp_battery_tenths  (rsp_battery_tenths)
   );

   // lanes start together and must stay in lockstep
   `IDL_ASSERT_NOW(a_lanes_lockstep,
      front_stat.busy || right_stat.busy || left_stat.busy,
      front_stat.busy && right_stat.busy && left_stat.busy)
   `IDL_ASSERT_NEXT(a_accept_clears_done, accept, !front_stat.done && front_stat.busy)
   `IDL_ASSERT_NOW(a_load_after_lanes, load, all_done && !front_stat.busy)
   `IDL_ASSERT_NEXT(a_load_shows_word, load, rsp_valid)
   `IDL_ASSERT_NOW(a_lane_busy_not_idle, front_stat.busy, state_ff == idl_pkg::ST_BUSY)

endmodule
